// ===== src/crfp_pkg.sv =====
`default_nettype none

package crfp_pkg;

  localparam int SOURCE_ID_BITS = 8;

  localparam int TIME_BITS  = 64;
  localparam int WIN_BITS   = 32;
  localparam int LIMIT_BITS = 8;
  localparam int FAIL_BITS  = 16;
  localparam int ATT_BITS   = 8;
  localparam int CODE_BITS  = 4;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_RETRY,
    ACT_REOPEN,
    ACT_RECREATE,
    ACT_SWITCH,
    ACT_WAIT,
    ACT_STOP
  } crfp_action_t;

  typedef enum logic {
    CMD_REPORT,
    CMD_OUTCOME
  } crfp_cmd_t;

  // Status codes with a meaning of their own; ranges are decoded by compare.
  localparam logic [CODE_BITS-1:0] ST_OK          = 4'd0;
  localparam logic [CODE_BITS-1:0] ST_TIMEOUT     = 4'd2;
  localparam logic [CODE_BITS-1:0] ST_REOPEN_LO   = 4'd3;
  localparam logic [CODE_BITS-1:0] ST_REOPEN_HI   = 4'd6;
  localparam logic [CODE_BITS-1:0] ST_DEVICE_LOST = 4'd7;
  localparam logic [CODE_BITS-1:0] ST_PERM_LO     = 4'd8;
  localparam logic [CODE_BITS-1:0] ST_PERM_HI     = 4'd10;
  localparam logic [CODE_BITS-1:0] ST_REOPEN2_LO  = 4'd11;
  localparam logic [CODE_BITS-1:0] ST_REOPEN2_HI  = 4'd13;
  localparam logic [CODE_BITS-1:0] ST_UNSUPPORTED = 4'd14;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 32;

  localparam logic [CFG_INDEX_BITS-1:0] REG_RECOVERY_WINDOW = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SAME_SRC_LIMIT  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PROMOTE_ENABLE  = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FAILED_COOLDOWN = 2'd3;

  typedef struct packed {
    logic [WIN_BITS-1:0]   recovery_window_usec;
    logic [LIMIT_BITS-1:0] same_source_limit;
    logic                  promote_enable;
    logic [WIN_BITS-1:0]   failed_cooldown_usec;
  } crfp_cfg_t;

  // Input item, tdata part; the last member sits in the lowest bits.
  typedef struct packed {
    logic                      attempt_succeeded;
    logic [TIME_BITS-1:0]      now_usec;
    logic [SOURCE_ID_BITS-1:0] source_id;
    logic                      recoverable;
    logic [CODE_BITS-1:0]      status_code;
  } crfp_in_t;

  typedef struct packed {
    crfp_action_t base_action;
    logic         request_keyframe;
    logic         keep_session;
  } crfp_decode_t;

  typedef struct packed {
    logic [SOURCE_ID_BITS-1:0] current_source;
    logic [TIME_BITS-1:0]      cooldown_until_usec;
    logic [ATT_BITS-1:0]       attempt_count;
    logic [FAIL_BITS-1:0]      failure_count;
    logic [WIN_BITS-1:0]       cooldown_remaining_usec;
    logic                      promoted_to_switch;
    logic                      blocked_by_cooldown;
    logic                      keep_session;
    logic                      request_keyframe;
    crfp_action_t              base_action;
    crfp_action_t              action;
  } crfp_out_t;

  localparam int IN_FIELD_BITS  = $bits(crfp_in_t);
  localparam int IN_TDATA_W     = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = $bits(crfp_out_t);
  localparam int OUT_TDATA_W    = ((OUT_FIELD_BITS + 7) / 8) * 8;

endpackage

`default_nettype wire

// ===== src/crfp_decode.sv =====
`default_nettype none

module crfp_decode
  import crfp_pkg::*;
(
  input  wire logic [CODE_BITS-1:0] status_code,
  input  wire logic                 recoverable,
  output crfp_decode_t              dec
);

  always_comb begin
    dec = '{base_action: ACT_NONE, request_keyframe: 1'b0, keep_session: 1'b0};
    if (status_code == ST_TIMEOUT) begin
      dec.base_action = ACT_RETRY;
    end else if ((status_code >= ST_REOPEN_LO && status_code <= ST_REOPEN_HI) ||
                 (status_code >= ST_REOPEN2_LO && status_code <= ST_REOPEN2_HI)) begin
      dec.base_action      = recoverable ? ACT_REOPEN : ACT_SWITCH;
      dec.request_keyframe = recoverable;
    end else if (status_code == ST_DEVICE_LOST) begin
      dec.base_action      = recoverable ? ACT_RECREATE : ACT_SWITCH;
      dec.request_keyframe = recoverable;
    end else if (status_code >= ST_PERM_LO && status_code <= ST_PERM_HI) begin
      dec.base_action  = ACT_WAIT;
      dec.keep_session = 1'b1;
    end else if (status_code == ST_UNSUPPORTED) begin
      dec.base_action  = ACT_SWITCH;
      dec.keep_session = 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== src/crfp_state.sv =====
`default_nettype none

module crfp_state
  import crfp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      fire,
  input  wire crfp_cmd_t command,
  input  wire crfp_in_t  item,
  input  wire crfp_cfg_t cfg,
  output crfp_out_t      result
);

  logic [SOURCE_ID_BITS-1:0] held_source, held_source_next;
  logic [FAIL_BITS-1:0]      consecutive_failures, consecutive_failures_next;
  logic [ATT_BITS-1:0]       same_source_attempts, same_source_attempts_next;
  logic [TIME_BITS-1:0]      last_attempt_time, last_attempt_time_next;
  logic [TIME_BITS-1:0]      cooldown_end_time, cooldown_end_time_next;
  crfp_action_t              pending_action, pending_action_next;

  crfp_decode_t              dec;
  logic [TIME_BITS:0]        window_sum;
  logic                      expired;
  logic [TIME_BITS:0]        cool_sum;
  logic [TIME_BITS-1:0]      cool_left;
  logic [SOURCE_ID_BITS-1:0] outcome_src;
  logic                      same_report;
  logic                      same_outcome;
  logic                      executable;
  logic                      cool_active;

  crfp_decode u_decode (
    .status_code (item.status_code),
    .recoverable (item.recoverable),
    .dec         (dec)
  );

  // The window sum is kept at 65 bits so that an overflowing sum never expires.
  assign window_sum = {1'b0, last_attempt_time} +
                      {{(TIME_BITS + 1 - WIN_BITS){1'b0}}, cfg.recovery_window_usec};
  assign expired = (last_attempt_time == '0) ||
                   ((cfg.recovery_window_usec != '0) &&
                    ({1'b0, item.now_usec} > window_sum));

  assign cool_sum  = {1'b0, item.now_usec} +
                     {{(TIME_BITS + 1 - WIN_BITS){1'b0}}, cfg.failed_cooldown_usec};
  assign cool_left = cooldown_end_time - item.now_usec;

  assign outcome_src  = (item.source_id != '0) ? item.source_id : held_source;
  assign same_report  = (held_source != '0) && (held_source == item.source_id);
  assign same_outcome = (held_source != '0) && (held_source == outcome_src);
  assign executable   = (dec.base_action == ACT_REOPEN) ||
                        (dec.base_action == ACT_RECREATE) ||
                        (dec.base_action == ACT_SWITCH);
  assign cool_active  = cooldown_end_time > item.now_usec;

  always_comb begin
    held_source_next          = held_source;
    consecutive_failures_next = consecutive_failures;
    same_source_attempts_next = same_source_attempts;
    last_attempt_time_next    = last_attempt_time;
    cooldown_end_time_next    = cooldown_end_time;
    pending_action_next       = pending_action;

    result                         = '0;
    result.action                  = ACT_NONE;
    result.base_action             = ACT_NONE;

    if (command == CMD_OUTCOME) begin
      held_source_next       = outcome_src;
      last_attempt_time_next = item.now_usec;
      if (pending_action == ACT_SWITCH || !same_outcome) begin
        same_source_attempts_next = '0;
      end else if (pending_action == ACT_REOPEN || pending_action == ACT_RECREATE) begin
        if (same_source_attempts != '1) begin
          same_source_attempts_next = same_source_attempts + 1'b1;
        end
      end
      if (item.attempt_succeeded) begin
        cooldown_end_time_next = '0;
      end else begin
        cooldown_end_time_next = cool_sum[TIME_BITS] ? '1 : cool_sum[TIME_BITS-1:0];
      end
    end else begin
      result.action           = dec.base_action;
      result.base_action      = dec.base_action;
      result.request_keyframe = dec.request_keyframe;
      result.keep_session     = dec.keep_session;
      held_source_next        = item.source_id;

      if (item.status_code == ST_OK) begin
        if (!same_report || expired) begin
          same_source_attempts_next = '0;
          last_attempt_time_next    = '0;
        end
        consecutive_failures_next = '0;
        cooldown_end_time_next    = '0;
      end else begin
        if (!same_report) begin
          consecutive_failures_next = FAIL_BITS'(1);
          same_source_attempts_next = '0;
          last_attempt_time_next    = '0;
          cooldown_end_time_next    = '0;
        end else begin
          if (consecutive_failures != '1) begin
            consecutive_failures_next = consecutive_failures + 1'b1;
          end
          if (expired) begin
            same_source_attempts_next = '0;
          end
        end

        // A live cooldown holds back executable actions, otherwise a run of
        // same-source attempts may escalate to a switch.
        if (executable && cool_active) begin
          result.blocked_by_cooldown     = 1'b1;
          result.cooldown_remaining_usec = (cool_left[TIME_BITS-1:WIN_BITS] != '0) ?
                                           '1 : cool_left[WIN_BITS-1:0];
          cooldown_end_time_next         = cooldown_end_time;
          result.action                  = ACT_RETRY;
          result.request_keyframe        = 1'b0;
        end else if (cfg.promote_enable && (cfg.same_source_limit != '0) &&
                     (dec.base_action == ACT_REOPEN || dec.base_action == ACT_RECREATE) &&
                     (same_source_attempts_next >= cfg.same_source_limit)) begin
          result.promoted_to_switch = 1'b1;
          result.action             = ACT_SWITCH;
          result.request_keyframe   = 1'b0;
        end
      end
      pending_action_next = result.action;
    end

    result.failure_count       = consecutive_failures_next;
    result.attempt_count       = same_source_attempts_next;
    result.cooldown_until_usec = cooldown_end_time_next;
    result.current_source      = held_source_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_source          <= '0;
      consecutive_failures <= '0;
      same_source_attempts <= '0;
      last_attempt_time    <= '0;
      cooldown_end_time    <= '0;
      pending_action       <= ACT_NONE;
    end else if (fire) begin
      held_source          <= held_source_next;
      consecutive_failures <= consecutive_failures_next;
      same_source_attempts <= same_source_attempts_next;
      last_attempt_time    <= last_attempt_time_next;
      cooldown_end_time    <= cooldown_end_time_next;
      pending_action       <= pending_action_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/capture_fault_recovery_policy.sv =====
// Escalating fault-recovery controller for a capture source. Each request on
// the slave stream is either a status report (tuser low) or a recovery
// attempt outcome (tuser high) and yields exactly one result on the master
// stream, in order. The block takes one request per clock cycle while the
// master side takes its results. A request waits in the input register; its
// result is loaded into the result register once that register is free or
// being taken, and is held there until the master side is ready. The
// recovery state (counters, source and cooldown time) is updated between
// those two registers. Configuration writes are meant for idle periods;
// after reset the configuration, the valid flags and the recovery state
// are zero, but the data registers are not reset.
`default_nettype none

module capture_fault_recovery_policy
  import crfp_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_write,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  // status_code, recoverable, source_id, now_usec, attempt_succeeded
  input  wire logic [IN_TDATA_W-1:0]     s_tdata,
  // command
  input  wire logic                      s_tuser,
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  // action, base_action, request_keyframe, keep_session, blocked_by_cooldown,
  // promoted_to_switch, cooldown_remaining_usec, failure_count, attempt_count,
  // cooldown_until_usec, current_source
  output logic [OUT_TDATA_W-1:0]         m_tdata
);

  crfp_cfg_t cfg;
  logic      in_valid;
  crfp_in_t  in_item;
  crfp_cmd_t in_cmd;
  crfp_out_t result;
  crfp_out_t out_item;
  logic      out_free;
  logic      fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_RECOVERY_WINDOW: cfg.recovery_window_usec <= cfg_data[WIN_BITS-1:0];
        REG_SAME_SRC_LIMIT:  cfg.same_source_limit    <= cfg_data[LIMIT_BITS-1:0];
        REG_PROMOTE_ENABLE:  cfg.promote_enable       <= cfg_data[0];
        REG_FAILED_COOLDOWN: cfg.failed_cooldown_usec <= cfg_data[WIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign out_free = !m_tvalid || m_tready;
  assign fire     = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item <= s_tdata[IN_FIELD_BITS-1:0];
      in_cmd  <= crfp_cmd_t'(s_tuser);
    end
  end

  crfp_state u_state (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .command (in_cmd),
    .item    (in_item),
    .cfg     (cfg),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item <= result;
    end
  end

  always_comb begin
    m_tdata                     = '0;
    m_tdata[OUT_FIELD_BITS-1:0] = out_item;
  end

endmodule

`default_nettype wire

// ===== src/crfp_checker.sv =====
`default_nettype none

module crfp_checker
  import crfp_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   m_tvalid,
  input wire logic                   m_tready,
  input wire logic [OUT_TDATA_W-1:0] m_tdata
);

  crfp_out_t res;

  assign res = m_tdata[OUT_FIELD_BITS-1:0];

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed or dropped");

  // A promoted plan is a switch that was not held back by the cooldown.
  a_promo: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res.promoted_to_switch |->
      res.action == ACT_SWITCH && !res.blocked_by_cooldown && !res.request_keyframe)
    else $error("promotion with inconsistent plan");

  // A blocked plan falls back to retry with some cooldown still left.
  a_blocked: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res.blocked_by_cooldown |->
      res.action == ACT_RETRY && res.cooldown_remaining_usec != '0 &&
      res.cooldown_until_usec != '0)
    else $error("blocked plan with inconsistent fields");

endmodule

bind capture_fault_recovery_policy crfp_checker u_crfp_checker (.*);

`default_nettype wire
